// ===== src/fhw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhw_pkg
// Shared types and constants of the frame history window: register codes,
// register field widths, the sequencer state type and the chain control
// bundle.
// ----------------------------------------------------------------------------
package fhw_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_RING_DEPTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_DIM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTION_DIM  = 2'd2;

  // register field widths and reset values
  localparam int HIST_CFG_W = 3;
  localparam int DIM_CFG_W  = 4;

  localparam logic [HIST_CFG_W-1:0] RING_DEPTH_RST  = 3'd4;
  localparam logic [DIM_CFG_W-1:0]  FEATURE_DIM_RST = 4'd12;
  localparam logic [DIM_CFG_W-1:0]  ACTION_DIM_RST  = 4'd0;

  // word position inside a row, and word count inside a frame
  localparam int COL_W = DIM_CFG_W;
  localparam int CNT_W = DIM_CFG_W + 1;

  // window sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEAT,
    ST_ACT
  } state_t;

  // control of one chain of word cells
  typedef struct packed {
    logic shift;  // move every cell one place toward the head
    logic load;   // tail takes the incoming word, else the head wraps around
  } chain_ctrl_t;

endpackage

// ===== src/fhw_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhw_cell
// One word cell of a chain: takes its upstream neighbor's word on a shift,
// or the chain's tail word when it is the last active cell.
// ----------------------------------------------------------------------------
module fhw_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic                 is_tail,
  input  logic [WORD_BITS-1:0] tail_in,
  input  logic [WORD_BITS-1:0] next_in,
  output logic [WORD_BITS-1:0] value
);

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (shift) begin
      value <= is_tail ? tail_in : next_in;
    end
  end

endmodule

// ===== src/fhw_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhw_chain
// A row of word cells. Words shift toward the head; the tail sits at
// position len-1 and takes either a new word (fill) or the head (rotate).
// After len rotations the row is back in its original order.
// ----------------------------------------------------------------------------
module fhw_chain #(
  parameter int WORD_BITS = 32,
  parameter int DEPTH     = 12
) (
  input  logic                        clk,
  input  fhw_pkg::chain_ctrl_t        ctrl,
  input  logic [fhw_pkg::COL_W-1:0]   len,
  input  logic [WORD_BITS-1:0]        din,
  output logic [WORD_BITS-1:0]        head
);
  import fhw_pkg::*;

  localparam int POS_W = $clog2(DEPTH + 1) + COL_W;

  logic [WORD_BITS-1:0] cell_q [DEPTH];
  logic [WORD_BITS-1:0] tail;
  logic [POS_W-1:0]     tail_pos;

  // tail source: new word or wrap-around of the head
  assign tail     = ctrl.load ? din : cell_q[0];
  assign tail_pos = POS_W'(len) - POS_W'(1);
  assign head     = cell_q[0];

  // cell row
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [WORD_BITS-1:0] upstream;
    if (j == DEPTH - 1) begin : g_end
      assign upstream = tail;
    end else begin : g_mid
      assign upstream = cell_q[j+1];
    end
    fhw_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk    (clk),
      .shift  (ctrl.shift),
      .is_tail(tail_pos == POS_W'(j)),
      .tail_in(tail),
      .next_in(upstream),
      .value  (cell_q[j])
    );
  end

endmodule

// ===== src/frame_history_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_history_window
// Ring of the most recent frames, streamed out as one flat window after
// every completed push frame.
// ----------------------------------------------------------------------------
// Frame words are taken one per cycle while the block is receiving. When a
// push frame completes, the input stalls while the window streams out one
// word per cycle unless the output stalls: ring_depth * feature_dim feature
// words, oldest frame first, then action_dim action words. Each stored row
// is a chain of word cells that rotates once per emitted word, so the window
// rate is set by one row head per cycle. Reset frames and partial frames
// emit nothing. No clearing pass follows reset; configuration writes drop
// any partial frame and make the next frame fill every row.
// ----------------------------------------------------------------------------
module frame_history_window #(
  parameter int MAX_HISTORY     = 4,
  parameter int MAX_FEATURE_DIM = 12,
  parameter int MAX_ACTION_DIM  = 12,
  parameter int WORD_BITS       = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [fhw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fhw_pkg::CFG_DATA_W-1:0]     cfg_data,
  // frame words in
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [WORD_BITS-1:0]               word,
  // window words out
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [WORD_BITS-1:0]               out_word,
  output logic                               is_action,
  output logic                               last_of_window
);
  import fhw_pkg::*;

  localparam int HIST_W    = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int SUM_W     = HIST_W + 2;
  localparam int ACT_CELLS = (MAX_ACTION_DIM > 0) ? MAX_ACTION_DIM : 1;
  localparam int CMP_W     = 8;

  // configuration registers
  logic [HIST_CFG_W-1:0] cfg_hist;
  logic [DIM_CFG_W-1:0]  cfg_feat;
  logic [DIM_CFG_W-1:0]  cfg_act;
  logic                  cfg_hit;

  // frame state
  logic [HIST_W-1:0] write_row;
  logic              filled;
  logic [CNT_W-1:0]  word_count;
  logic              frame_is_reset;

  // window sequencer
  state_t            state;
  state_t            state_next;
  logic [HIST_W-1:0] emit_row;
  logic [COL_W-1:0]  emit_col;
  logic              out_valid_next;

  // effective dimensions
  logic [SUM_W-1:0] eff_h;
  logic [COL_W-1:0] eff_f;
  logic [COL_W-1:0] eff_a;
  logic [CNT_W-1:0] frame_len;

  // datapath controls
  logic              in_fire;
  logic              cur_reset;
  logic              fill_all;
  logic              is_feat_word;
  logic              frame_done;
  logic              start_emit;
  logic [HIST_W-1:0] wr;
  logic [HIST_W-1:0] wr_adv;
  logic [SUM_W-1:0]  wr_p1;
  logic [SUM_W-1:0]  sel_sum;
  logic [HIST_W-1:0] sel_row;
  logic              emit_load;
  logic              col_end;
  logic              row_end;
  logic              act_end;
  logic              emit_last;

  chain_ctrl_t          row_ctrl [MAX_HISTORY];
  chain_ctrl_t          act_ctrl;
  logic [WORD_BITS-1:0] row_head [MAX_HISTORY];
  logic [WORD_BITS-1:0] act_head;

  // clamp register values to their working ranges
  always_comb begin
    if (cfg_hist == '0) begin
      eff_h = SUM_W'(1);
    end else if (CMP_W'(cfg_hist) > CMP_W'(MAX_HISTORY)) begin
      eff_h = SUM_W'(MAX_HISTORY);
    end else begin
      eff_h = SUM_W'(cfg_hist);
    end
    if (cfg_feat == '0) begin
      eff_f = COL_W'(1);
    end else if (CMP_W'(cfg_feat) > CMP_W'(MAX_FEATURE_DIM)) begin
      eff_f = COL_W'(MAX_FEATURE_DIM);
    end else begin
      eff_f = cfg_feat;
    end
    if (CMP_W'(cfg_act) > CMP_W'(MAX_ACTION_DIM)) begin
      eff_a = COL_W'(MAX_ACTION_DIM);
    end else begin
      eff_a = cfg_act;
    end
  end

  assign frame_len = CNT_W'(eff_f) + CNT_W'(eff_a);

  // configuration decode
  assign cfg_hit = cfg_write && (cfg_index == REG_RING_DEPTH ||
                                 cfg_index == REG_FEATURE_DIM ||
                                 cfg_index == REG_ACTION_DIM);

  // input request bookkeeping
  assign in_stall     = (state != ST_IDLE);
  assign in_fire      = in_valid && !in_stall;
  assign cur_reset    = (word_count == '0) ? kind : frame_is_reset;
  assign fill_all     = cur_reset || !filled;
  assign is_feat_word = word_count < CNT_W'(eff_f);
  assign frame_done   = (word_count + CNT_W'(1)) == frame_len;
  assign start_emit   = in_fire && frame_done && !cur_reset && !cfg_hit;

  // write row, kept inside the ring, and its successor
  assign wr     = (SUM_W'(write_row) >= eff_h) ? '0 : write_row;
  assign wr_p1  = SUM_W'(wr) + SUM_W'(1);
  assign wr_adv = (wr_p1 == eff_h) ? '0 : wr_p1[HIST_W-1:0];

  // row being emitted: oldest row plus offset, modulo ring depth
  assign sel_sum = SUM_W'(write_row) + SUM_W'(emit_row);
  assign sel_row = (sel_sum >= eff_h) ? HIST_W'(sel_sum - eff_h) : sel_sum[HIST_W-1:0];

  // emission position flags
  assign col_end = (emit_col == eff_f - COL_W'(1));
  assign row_end = (SUM_W'(emit_row) + SUM_W'(1)) == eff_h;
  assign act_end = (emit_col == eff_a - COL_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_emit) begin
          state_next = ST_FEAT;
        end
      end
      ST_FEAT: begin
        if (emit_load && col_end && row_end) begin
          state_next = (eff_a == '0) ? ST_IDLE : ST_ACT;
        end
      end
      ST_ACT: begin
        if (emit_load && act_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and chain controls
  always_comb begin
    emit_load      = (state != ST_IDLE) && (!out_valid || !out_stall);
    out_valid_next = emit_load || (out_valid && out_stall);
    emit_last      = 1'b0;
    unique case (state)
      ST_FEAT: emit_last = (eff_a == '0) && col_end && row_end;
      ST_ACT:  emit_last = act_end;
      default: emit_last = 1'b0;
    endcase
    for (int r = 0; r < MAX_HISTORY; r++) begin
      row_ctrl[r].load  = in_fire && is_feat_word &&
                          (fill_all ? (SUM_W'(r) < eff_h) : (HIST_W'(r) == wr));
      row_ctrl[r].shift = row_ctrl[r].load ||
                          (state == ST_FEAT && emit_load && sel_row == HIST_W'(r));
    end
    act_ctrl.load  = in_fire && !is_feat_word;
    act_ctrl.shift = act_ctrl.load || (state == ST_ACT && emit_load);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cfg_hist       <= RING_DEPTH_RST;
      cfg_feat       <= FEATURE_DIM_RST;
      cfg_act        <= ACTION_DIM_RST;
      write_row      <= '0;
      filled         <= 1'b0;
      word_count     <= '0;
      frame_is_reset <= 1'b0;
      emit_row       <= '0;
      emit_col       <= '0;
      out_valid      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      // register writes
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RING_DEPTH:  cfg_hist <= cfg_data[HIST_CFG_W-1:0];
          REG_FEATURE_DIM: cfg_feat <= cfg_data[DIM_CFG_W-1:0];
          REG_ACTION_DIM:  cfg_act  <= cfg_data[DIM_CFG_W-1:0];
          default: ;
        endcase
      end
      // frame tracking
      if (cfg_hit) begin
        write_row      <= '0;
        filled         <= 1'b0;
        word_count     <= '0;
        frame_is_reset <= 1'b0;
      end else if (in_fire) begin
        frame_is_reset <= cur_reset;
        if (frame_done) begin
          word_count <= '0;
          filled     <= 1'b1;
          write_row  <= fill_all ? '0 : wr_adv;
        end else begin
          word_count <= word_count + CNT_W'(1);
        end
      end
      // window position
      if (start_emit) begin
        emit_row <= '0;
        emit_col <= '0;
      end else if (emit_load) begin
        if (state == ST_FEAT && col_end) begin
          emit_col <= '0;
          emit_row <= emit_row + HIST_W'(1);
        end else begin
          emit_col <= emit_col + COL_W'(1);
        end
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_word       <= (state == ST_ACT) ? act_head : row_head[sel_row];
      is_action      <= (state == ST_ACT);
      last_of_window <= emit_last;
    end
  end

  // one chain of cells per stored frame
  for (genvar r = 0; r < MAX_HISTORY; r++) begin : g_row
    fhw_chain #(
      .WORD_BITS(WORD_BITS),
      .DEPTH    (MAX_FEATURE_DIM)
    ) u_row (
      .clk (clk),
      .ctrl(row_ctrl[r]),
      .len (eff_f),
      .din (word),
      .head(row_head[r])
    );
  end

  // newest action words
  fhw_chain #(
    .WORD_BITS(WORD_BITS),
    .DEPTH    (ACT_CELLS)
  ) u_act (
    .clk (clk),
    .ctrl(act_ctrl),
    .len (eff_a),
    .din (word),
    .head(act_head)
  );

  // checks
  a_write_row_in_ring: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(write_row) < eff_h)
    else $error("write row outside the ring");

  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    word_count < frame_len)
    else $error("word count past frame length");

  a_push_starts_window: assert property (@(posedge clk) disable iff (rst)
    start_emit |=> state == ST_FEAT && emit_row == '0 && emit_col == '0)
    else $error("completed push did not start a window");

  a_last_ends_window: assert property (@(posedge clk) disable iff (rst)
    emit_load && emit_last |=> out_valid && last_of_window && state == ST_IDLE)
    else $error("window did not end on its last word");

endmodule
